### hw/rtl/rgnu_pkg.sv
// Shared types and constants for the RTCP generic NACK unpacker.
package rgnu_pkg;

    localparam logic [3:0] HDR_SSRC_BYTES = 4'd4;
    localparam logic [3:0] HDR_BYTES      = 4'd8;
    localparam logic [3:0] HDR_DONE_ITEM  = 4'd9;
    localparam logic [1:0] ITEM_LAST      = 2'd3;

    typedef enum logic [1:0] {
        KIND_ID    = 2'd0,
        KIND_END   = 2'd1,
        KIND_SHORT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PID,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        item;
        logic        fin;
        logic        ended;
        logic [15:0] pid;
        logic [15:0] mask;
        logic [31:0] sender;
        logic [31:0] media;
    } t_job;

endpackage

### hw/rtl/rgnu_ifs.sv
// Valid/ready channel interfaces for payload bytes and results.
interface rgnu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       byte_is_final;

    modport source (output valid, output payload_byte, output byte_is_final, input ready);
    modport sink   (input valid, input payload_byte, input byte_is_final, output ready);
endinterface

interface rgnu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] lost_packet_id;
    logic [31:0] sender_ssrc_out;
    logic [31:0] media_ssrc_out;
    logic        run_last;

    modport source (output valid, output result_kind, output lost_packet_id,
                    output sender_ssrc_out, output media_ssrc_out, output run_last,
                    input ready);
    modport sink   (input valid, input result_kind, input lost_packet_id,
                    input sender_ssrc_out, input media_ssrc_out, input run_last,
                    output ready);
endinterface

### hw/rtl/rgnu_capture.sv
// Header and NACK item byte capture.
module rgnu_capture (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_final,
    output rgnu_pkg::t_job o_job
);
    import rgnu_pkg::*;

    logic [3:0]  r_hdr_cnt;
    logic [1:0]  r_phase;
    logic [23:0] r_item;
    logic [31:0] r_sender;
    logic [31:0] r_media;
    logic        item_done;

    assign item_done = (r_hdr_cnt >= HDR_BYTES) && (r_phase == ITEM_LAST);

    always_comb begin
        o_job.item   = item_done;
        o_job.fin    = i_final;
        o_job.ended  = item_done || (r_hdr_cnt == HDR_DONE_ITEM);
        o_job.pid    = r_item[23:8];
        o_job.mask   = {r_item[7:0], i_byte};
        o_job.sender = r_sender;
        o_job.media  = r_media;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
            r_phase   <= '0;
            r_item    <= '0;
            r_sender  <= '0;
            r_media   <= '0;
        end else if (i_take) begin
            if (i_final) begin
                r_hdr_cnt <= '0;
                r_phase   <= '0;
                r_item    <= '0;
                r_sender  <= '0;
                r_media   <= '0;
            end else if (r_hdr_cnt < HDR_SSRC_BYTES) begin
                r_sender  <= {r_sender[23:0], i_byte};
                r_hdr_cnt <= r_hdr_cnt + 4'd1;
            end else if (r_hdr_cnt < HDR_BYTES) begin
                r_media   <= {r_media[23:0], i_byte};
                r_hdr_cnt <= r_hdr_cnt + 4'd1;
            end else if (!item_done) begin
                r_item  <= {r_item[15:0], i_byte};
                r_phase <= r_phase + 2'd1;
            end else begin
                r_item    <= '0;
                r_phase   <= '0;
                r_hdr_cnt <= HDR_DONE_ITEM;
            end
        end
    end

endmodule

### hw/rtl/rgnu_scan.sv
// Result sequencer: one incrementer walks the loss mask a bit a cycle unless stalled.
module rgnu_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rgnu_pkg::t_job i_job,
    input  logic           i_out_ready,
    output logic           o_idle,
    output logic           o_valid,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_id,
    output logic [31:0]    o_sender,
    output logic [31:0]    o_media,
    output logic           o_last
);
    import rgnu_pkg::*;

    t_state      r_state, n_state;
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_mask, n_mask;
    logic        r_fin, n_fin;
    logic        r_ended, n_ended;
    logic [31:0] r_sender, n_sender;
    logic [31:0] r_media, n_media;
    logic        r_valid, n_valid;
    t_kind       r_kind, n_kind;
    logic [15:0] r_id, n_id;
    logic [31:0] r_osnd, n_osnd;
    logic [31:0] r_omed, n_omed;
    logic        r_last, n_last;
    logic        slot_free;
    logic        mask_rest_zero;
    logic [15:0] id_inc;

    assign slot_free      = !r_valid || i_out_ready;
    assign mask_rest_zero = (r_mask[15:1] == 15'd0);
    assign id_inc         = r_cur + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_mask   <= n_mask;
        r_fin    <= n_fin;
        r_ended  <= n_ended;
        r_sender <= n_sender;
        r_media  <= n_media;
        r_kind   <= n_kind;
        r_id     <= n_id;
        r_osnd   <= n_osnd;
        r_omed   <= n_omed;
        r_last   <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_mask   = r_mask;
        n_fin    = r_fin;
        n_ended  = r_ended;
        n_sender = r_sender;
        n_media  = r_media;
        n_valid  = r_valid && !i_out_ready;
        n_kind   = r_kind;
        n_id     = r_id;
        n_osnd   = r_osnd;
        n_omed   = r_omed;
        n_last   = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cur    = i_job.pid;
                    n_mask   = i_job.mask;
                    n_fin    = i_job.fin;
                    n_ended  = i_job.ended;
                    n_sender = i_job.sender;
                    n_media  = i_job.media;
                    if (i_job.item) begin
                        n_state = ST_PID;
                    end else if (i_job.fin) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_PID: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_ID;
                    n_id    = r_cur;
                    n_osnd  = r_sender;
                    n_omed  = r_media;
                    n_last  = (r_mask == 16'd0) && !r_fin;
                    if (r_mask != 16'd0) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = r_fin ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (slot_free || !r_mask[0]) begin
                    if (r_mask[0]) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_ID;
                        n_id    = id_inc;
                        n_osnd  = r_sender;
                        n_omed  = r_media;
                        n_last  = mask_rest_zero && !r_fin;
                    end
                    n_cur  = id_inc;
                    n_mask = {1'b0, r_mask[15:1]};
                    if (mask_rest_zero) begin
                        n_state = r_fin ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_kind  = r_ended ? KIND_END : KIND_SHORT;
                    n_id    = 16'd0;
                    n_osnd  = r_ended ? r_sender : 32'd0;
                    n_omed  = r_ended ? r_media : 32'd0;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle   = (r_state == ST_IDLE);
    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_id     = r_id;
    assign o_sender = r_osnd;
    assign o_media  = r_omed;
    assign o_last   = r_last;

endmodule

### hw/rtl/rtcp_generic_nack_unpacker_top.sv
// Top level: RTCP generic NACK payload unpacker.
// A byte that completes no item leaves the scan sequencer idle, unless it is final.
// A byte that completes an item emits its packet id, then walks the mask up to the highest
// set bit; a final byte then adds an end word. Output stalls hold the sequencer meanwhile.
// Rate is set by the single-bit mask walk in the scan sequencer.
// Synchronous active-low reset clears the parse state and empties the output register.
module rtcp_generic_nack_unpacker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgnu_in_if.sink    i_in,
    rgnu_out_if.source o_out
);
    import rgnu_pkg::*;

    t_job job;
    logic idle;
    logic take;

    assign take       = i_in.valid && idle;
    assign i_in.ready = idle;

    rgnu_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.payload_byte),
        .i_final (i_in.byte_is_final),
        .o_job   (job)
    );

    rgnu_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (take),
        .i_job       (job),
        .i_out_ready (o_out.ready),
        .o_idle      (idle),
        .o_valid     (o_out.valid),
        .o_kind      (o_out.result_kind),
        .o_id        (o_out.lost_packet_id),
        .o_sender    (o_out.sender_ssrc_out),
        .o_media     (o_out.media_ssrc_out),
        .o_last      (o_out.run_last)
    );

endmodule

### hw/rtl/rgnu_checker.sv
// Port-level assertions for the NACK unpacker, bound to the top level.
module rgnu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_id,
    input logic [31:0] i_sender,
    input logic [31:0] i_media,
    input logic        i_last
);
    import rgnu_pkg::*;

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_ID || i_kind == KIND_END || i_kind == KIND_SHORT))
        else $error("illegal result kind");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind != KIND_ID) |-> (i_last && i_id == 16'd0))
        else $error("end word not last or id nonzero");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_SHORT) |-> (i_sender == 32'd0 && i_media == 32'd0))
        else $error("too-short word carries ssrc");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind) && $stable(i_id)
            && $stable(i_sender) && $stable(i_media) && $stable(i_last)))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("not empty after reset");

endmodule

bind rtcp_generic_nack_unpacker_top rgnu_checker u_rgnu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.result_kind),
    .i_id        (o_out.lost_packet_id),
    .i_sender    (o_out.sender_ssrc_out),
    .i_media     (o_out.media_ssrc_out),
    .i_last      (o_out.run_last)
);

### verif/testbench.sv
// Self-checking testbench for the RTCP generic NACK payload unpacker.
`timescale 1ns / 1ps

module testbench;
    import rgnu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_BYTES  = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] id;
        logic [31:0] sender;
        logic [31:0] media;
        logic        last;
    } nack_res_t;

    // typed = 1: the row's single result is given here, not predicted
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        typed;
        t_kind       kind;
        logic [31:0] sender;
        logic [31:0] media;
    } stim_t;

    logic clk;
    logic rst_n;

    rgnu_in_if  in_if ();
    rgnu_out_if out_if ();

    rtcp_generic_nack_unpacker_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    stim_t     dir_tab [DIR_ROWS];
    stim_t     stim_q [$];
    nack_res_t lost_q [$];

    // predictor state
    logic [3:0]  hdr_cnt    = '0;
    logic [1:0]  item_phase = '0;
    logic [23:0] item_buf   = '0;
    logic [31:0] snd_ssrc   = '0;
    logic [31:0] med_ssrc   = '0;
    nack_res_t   pend [18];
    int          pend_n;

    int  acc_cnt = 0;
    int  got_cnt = 0;
    int  err_cnt = 0;
    int  cyc     = 0;
    int  n_payloads = 0;
    int  n_ids = 0;
    int  n_ends = 0;
    int  n_shorts = 0;
    logic hold_on;

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    task automatic add_lost(input nack_res_t r);
        lost_q.insert(lost_q.size(), r);
    endtask

    task automatic add_stim(input stim_t s);
        stim_q.insert(stim_q.size(), s);
    endtask

    task nack_step(input logic [7:0] b, input logic fin);
        logic [15:0] pid;
        logic [15:0] mask;
        pend_n = 0;
        if (hdr_cnt < HDR_SSRC_BYTES) begin
            snd_ssrc = {snd_ssrc[23:0], b};
            hdr_cnt++;
        end else if (hdr_cnt < HDR_BYTES) begin
            med_ssrc = {med_ssrc[23:0], b};
            hdr_cnt++;
        end else if (item_phase < ITEM_LAST) begin
            item_buf = {item_buf[15:0], b};
            item_phase++;
        end else begin
            pid  = item_buf[23:8];
            mask = {item_buf[7:0], b};
            pend[pend_n] = '{KIND_ID, pid, snd_ssrc, med_ssrc, 1'b0};
            pend_n++;
            for (int k = 0; k < 16; k++) begin
                if (mask[k]) begin
                    pend[pend_n] = '{KIND_ID, pid + 16'(k) + 16'd1, snd_ssrc, med_ssrc, 1'b0};
                    pend_n++;
                end
            end
            item_phase = '0;
            item_buf   = '0;
            hdr_cnt    = HDR_DONE_ITEM;
        end
        if (fin) begin
            if (hdr_cnt == HDR_DONE_ITEM)
                pend[pend_n] = '{KIND_END, 16'd0, snd_ssrc, med_ssrc, 1'b0};
            else
                pend[pend_n] = '{KIND_SHORT, 16'd0, 32'd0, 32'd0, 1'b0};
            pend_n++;
            hdr_cnt    = '0;
            item_phase = '0;
            item_buf   = '0;
            snd_ssrc   = '0;
            med_ssrc   = '0;
        end
        if (pend_n > 0) pend[pend_n - 1].last = 1'b1;
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending", cyc, lost_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // sender
    initial begin
        in_if.valid         = 1'b0;
        in_if.payload_byte  = '0;
        in_if.byte_is_final = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (in_if.valid && in_if.ready) begin
                    nack_step(stim_q[acc_cnt].data, stim_q[acc_cnt].fin);
                    if (stim_q[acc_cnt].fin) n_payloads++;
                    if (stim_q[acc_cnt].typed) begin
                        add_lost('{stim_q[acc_cnt].kind, 16'd0,
                                   stim_q[acc_cnt].sender, stim_q[acc_cnt].media, 1'b1});
                    end else begin
                        for (int i = 0; i < pend_n; i++) add_lost(pend[i]);
                    end
                    acc_cnt++;
                end
                if (!in_if.valid || in_if.ready) begin
                    if (acc_cnt < stim_q.size() &&
                        ((acc_cnt >= 120 && acc_cnt < 190) || $urandom_range(99) >= 10)) begin
                        in_if.valid         <= 1'b1;
                        in_if.payload_byte  <= stim_q[acc_cnt].data;
                        in_if.byte_is_final <= stim_q[acc_cnt].fin;
                    end else begin
                        in_if.valid <= 1'b0;
                    end
                end
            end
        end
    end

    // long receiver hold-off once the output has moved a fair number of words
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_on   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && got_cnt >= 40) begin
                hold_on   <= 1'b1;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0) hold_on <= 1'b0;
            end
        end
    end

    // receiver and checker
    initial begin
        nack_res_t want;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                out_if.ready <= 1'b0;
            end else begin
                if (out_if.valid && out_if.ready) begin
                    got_cnt <= got_cnt + 1;
                    case (out_if.result_kind)
                        KIND_ID:    n_ids++;
                        KIND_END:   n_ends++;
                        KIND_SHORT: n_shorts++;
                        default:    ;
                    endcase
                    if (lost_q.size() == 0) begin
                        note_error($sformatf("unexpected word: kind %0d id %h snd %h med %h last %b",
                                             out_if.result_kind, out_if.lost_packet_id,
                                             out_if.sender_ssrc_out, out_if.media_ssrc_out,
                                             out_if.run_last));
                    end else begin
                        want = lost_q.pop_front();
                        if (out_if.result_kind !== want.kind ||
                            out_if.lost_packet_id !== want.id ||
                            out_if.sender_ssrc_out !== want.sender ||
                            out_if.media_ssrc_out !== want.media ||
                            out_if.run_last !== want.last) begin
                            note_error($sformatf({"mismatch at word %0d: exp kind %0d id %h ",
                                                  "snd %h med %h last %b, got kind %0d id %h ",
                                                  "snd %h med %h last %b"},
                                                 got_cnt, want.kind, want.id, want.sender,
                                                 want.media, want.last, out_if.result_kind,
                                                 out_if.lost_packet_id, out_if.sender_ssrc_out,
                                                 out_if.media_ssrc_out, out_if.run_last));
                        end
                    end
                end
                out_if.ready <= !hold_on &&
                                ((got_cnt >= 80 && got_cnt < 160) || $urandom_range(99) >= 10);
            end
        end
    end

    initial begin
        logic [7:0]  pl [$];
        logic [15:0] pid;
        logic [15:0] mask;
        int n_items;
        int trail;
        int len;
        int rand_bytes;

        rst_n = 1'b0;

        dir_tab = '{
            // too short right after reset
            '{8'h00, 1'b1, 1'b1, KIND_SHORT, 32'h0, 32'h0},
            // sender SSRC all ones, media SSRC all zeros
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            // id FFFF, full mask: 17 ids wrapping through zero
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            // id 0000, empty mask
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h00, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            // partial trailing item ignored, then end
            '{8'hA5, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h5A, 1'b1, 1'b1, KIND_END, 32'hFFFF_FFFF, 32'h0},
            // short payload ending inside the media SSRC
            '{8'h12, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h34, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h56, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h78, 1'b0, 1'b0, KIND_ID, 32'h0, 32'h0},
            '{8'h9A, 1'b1, 1'b1, KIND_SHORT, 32'h0, 32'h0}
        };
        foreach (dir_tab[i]) add_stim(dir_tab[i]);

        // mostly well-formed payloads, some cut at random lengths
        rand_bytes = 0;
        while (rand_bytes < RAND_BYTES) begin
            pl.delete();
            if ($urandom_range(99) < 80) begin
                n_items = $urandom_range(4);
                trail   = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
                for (int i = 0; i < 8; i++) pl.insert(pl.size(), 8'($urandom));
                for (int i = 0; i < n_items; i++) begin
                    pid = 16'($urandom);
                    case ($urandom_range(3))
                        0:       mask = 16'h0000;
                        1:       mask = 16'hFFFF;
                        2:       mask = 16'h0001 << $urandom_range(15);
                        default: mask = 16'($urandom);
                    endcase
                    pl.insert(pl.size(), pid[15:8]);
                    pl.insert(pl.size(), pid[7:0]);
                    pl.insert(pl.size(), mask[15:8]);
                    pl.insert(pl.size(), mask[7:0]);
                end
                for (int i = 0; i < trail; i++) pl.insert(pl.size(), 8'($urandom));
            end else begin
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++) pl.insert(pl.size(), 8'($urandom));
            end
            foreach (pl[i])
                add_stim('{pl[i], i == pl.size() - 1, 1'b0, KIND_ID, 32'h0, 32'h0});
            rand_bytes += pl.size();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (acc_cnt < stim_q.size() || lost_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d payload bytes in %0d payloads sent, including a %0d-cycle output hold-off",
                 stim_q.size(), n_payloads, HOLD_CYCLES);
        $display("%0d words checked: %0d lost ids, %0d payload ends, %0d too-short errors",
                 got_cnt, n_ids, n_ends, n_shorts);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rgnu_pkg.sv
hw/rtl/rgnu_ifs.sv
hw/rtl/rgnu_capture.sv
hw/rtl/rgnu_scan.sv
hw/rtl/rtcp_generic_nack_unpacker_top.sv
hw/rtl/rgnu_checker.sv
verif/testbench.sv
